// ===== src/ict_pkg.sv =====
package ict_pkg;

  // Instruction kinds carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_ADDIS = 2'd0,
    CMD_ADDI  = 2'd1,
    CMD_ORI   = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_e;

  localparam int NUM_REGS_DEFAULT = 32;
  localparam int IMM_SHIFT = 16;

  localparam int REG_W   = 5;
  localparam int IMM_W   = 16;
  localparam int DEF_W   = 6;
  localparam int VALUE_W = 32;

  // Input tdata layout, lowest bit first.
  localparam int IN_FIRST_LSB = 0;
  localparam int IN_DEST_LSB  = 1;
  localparam int IN_SRC_LSB   = IN_DEST_LSB + REG_W;
  localparam int IN_IMM_LSB   = IN_SRC_LSB + REG_W;
  localparam int IN_DEF_LSB   = IN_IMM_LSB + IMM_W;
  localparam int IN_BITS      = IN_DEF_LSB + DEF_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

endpackage

// ===== src/ict_ram.sv =====
module ict_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/immediate_constant_tracker_unit.sv =====
// Channel   Direction  tdata                                         tuser
// s_axis    in         first_of_block, dest_reg, src_reg,            command
//                      immediate, defined_reg (40 bits, zero pad)
// m_axis    out        constant_value (32 bits)                      has_constant
//
// One instruction per cycle while the output is not stalled: the shadow value
// memory is read as an instruction is accepted, and the add or OR and the
// shadow write happen as it moves into the output register.
// A write that lands at the same edge as the read is forwarded.
// Reset clears the known flags and the pipeline valids; no clearing pass.
// A stalled output holds the result and the pipeline accepts until both stages are full.
module immediate_constant_tracker_unit #(
  parameter int NUM_REGS = ict_pkg::NUM_REGS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [0] first_of_block, [5:1] dest_reg, [10:6] src_reg, [26:11] immediate,
  // [32:27] defined_reg, [39:33] zero
  input  logic [ict_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] constant_value
  output logic [ict_pkg::VALUE_W-1:0]   m_axis_tdata_o,
  // [0] has_constant
  output logic                          m_axis_tuser_o
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int IDX_W = 7;

  // Stage 1: accepted instruction waiting for its shadow value.
  logic                        s1_valid_q;
  ict_pkg::cmd_e               s1_cmd_q;
  logic                        s1_first_q;
  logic [ict_pkg::REG_W-1:0]   s1_dest_q;
  logic [ict_pkg::REG_W-1:0]   s1_src_q;
  logic [ict_pkg::IMM_W-1:0]   s1_imm_q;
  logic [ict_pkg::DEF_W-1:0]   s1_def_q;
  logic                        byp_hit_q;
  logic [ict_pkg::VALUE_W-1:0] byp_data_q;

  logic [NUM_REGS-1:0]         known_q, known_d;

  logic                        out_valid_q;
  logic                        out_has_q;
  logic [ict_pkg::VALUE_W-1:0] out_value_q;

  logic accept, advance;

  ict_pkg::cmd_e             in_cmd;
  logic [ict_pkg::REG_W-1:0] in_dest, in_src, in_rd_idx;
  logic [IDX_W-1:0]          in_rd_wide, wr_wide;

  logic [ict_pkg::VALUE_W-1:0] ram_rdata, src_value, imm_value, sum_value;
  logic [NUM_REGS-1:0]         known_eff;
  logic [ict_pkg::REG_W-1:0]   rd_idx, wr_idx;
  logic                        src_known, ok, wr_en, ram_we;
  logic [ict_pkg::VALUE_W-1:0] result_value;

  assign advance         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_cmd  = ict_pkg::cmd_e'(s_axis_tuser_i);
  assign in_dest = s_axis_tdata_i[ict_pkg::IN_DEST_LSB +: ict_pkg::REG_W];
  assign in_src  = s_axis_tdata_i[ict_pkg::IN_SRC_LSB +: ict_pkg::REG_W];
  // The ori form reads the rd field; the add forms read the ra field.
  assign in_rd_idx  = (in_cmd == ict_pkg::CMD_ORI) ? in_dest : in_src;
  assign in_rd_wide = {{(IDX_W - ict_pkg::REG_W){1'b0}}, in_rd_idx};

  // Stage 1 compute.
  assign rd_idx    = (s1_cmd_q == ict_pkg::CMD_ORI) ? s1_dest_q : s1_src_q;
  assign wr_idx    = (s1_cmd_q == ict_pkg::CMD_ORI) ? s1_src_q : s1_dest_q;
  assign wr_wide   = {{(IDX_W - ict_pkg::REG_W){1'b0}}, wr_idx};
  assign known_eff = s1_first_q ? '0 : known_q;
  assign src_value = byp_hit_q ? byp_data_q : ram_rdata;

  always_comb begin
    src_known = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (int'(rd_idx) == i) begin
        src_known = known_eff[i];
      end
    end
  end

  always_comb begin
    if (s1_cmd_q == ict_pkg::CMD_ADDIS) begin
      imm_value = {s1_imm_q, {ict_pkg::IMM_SHIFT{1'b0}}};
    end else begin
      imm_value = {{(ict_pkg::VALUE_W - ict_pkg::IMM_W){s1_imm_q[ict_pkg::IMM_W-1]}}, s1_imm_q};
    end
  end

  assign sum_value = src_value + imm_value;

  always_comb begin
    ok           = 1'b0;
    result_value = '0;
    wr_en        = 1'b0;
    case (s1_cmd_q) inside
      ict_pkg::CMD_ADDIS, ict_pkg::CMD_ADDI: begin
        wr_en = 1'b1;
        if (s1_src_q == '0) begin
          ok           = 1'b1;
          result_value = imm_value;
        end else if (src_known) begin
          ok           = 1'b1;
          result_value = sum_value;
        end
      end
      ict_pkg::CMD_ORI: begin
        wr_en = 1'b1;
        if (src_known) begin
          ok           = 1'b1;
          result_value = src_value |
                         {{(ict_pkg::VALUE_W - ict_pkg::IMM_W){1'b0}}, s1_imm_q};
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    known_d = known_q;
    if (advance) begin
      known_d = known_eff;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (wr_en && int'(wr_idx) == i) begin
          known_d[i] = ok;
        end
        if (s1_cmd_q == ict_pkg::CMD_OTHER && int'(s1_def_q) == i) begin
          known_d[i] = 1'b0;
        end
      end
    end
  end

  // Values only matter while known, so only known results are stored.
  assign ram_we = advance && wr_en && ok && (int'(wr_idx) < NUM_REGS);

  ict_ram #(
    .WIDTH (ict_pkg::VALUE_W),
    .DEPTH (NUM_REGS)
  ) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_wide[AW-1:0]),
    .wdata_i (result_value),
    .re_i    (accept),
    .raddr_i (in_rd_wide[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      known_q     <= '0;
    end else begin
      known_q <= known_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q   <= in_cmd;
      s1_first_q <= s_axis_tdata_i[ict_pkg::IN_FIRST_LSB];
      s1_dest_q  <= in_dest;
      s1_src_q   <= in_src;
      s1_imm_q   <= s_axis_tdata_i[ict_pkg::IN_IMM_LSB +: ict_pkg::IMM_W];
      s1_def_q   <= s_axis_tdata_i[ict_pkg::IN_DEF_LSB +: ict_pkg::DEF_W];
      byp_hit_q  <= ram_we && (wr_idx == in_rd_idx);
      byp_data_q <= result_value;
    end
    if (advance) begin
      out_has_q   <= ok;
      out_value_q <= result_value;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_has_q;

endmodule

// ===== src/ict_checker.sv =====
module ict_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [ict_pkg::VALUE_W-1:0]    m_axis_tdata_o,
  input logic                           m_axis_tuser_o
);

  // A result without a constant carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("result without constant has nonzero value");

  // The input side only backs up when the output side is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled while output could drain");

  // An accepted transaction into an empty block passes stage 1 and reaches the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o && m_axis_tready_i
    ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("accepted transaction produced no result");

  // A stalled result holds its content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind immediate_constant_tracker_unit ict_checker u_ict_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIR_ROWS     = 23;

  typedef struct packed {
    ict_pkg::cmd_e                    cmd;
    logic                             first;
    logic [ict_pkg::REG_W-1:0]        rd;
    logic [ict_pkg::REG_W-1:0]        ra;
    logic [ict_pkg::IMM_W-1:0]        imm;
    logic [ict_pkg::DEF_W-1:0]        def;
  } instr_t;

  typedef struct packed {
    logic                        has_constant;
    logic [ict_pkg::VALUE_W-1:0] constant_value;
  } tracked_t;

  typedef struct packed {
    instr_t   ins;
    logic     typed;
    tracked_t res;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_valid = 1'b0;
  logic [ict_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]                     s_tuser = ict_pkg::CMD_OTHER;
  logic                           m_ready = 1'b1;
  logic                           s_ready;
  logic                           m_valid;
  logic [ict_pkg::VALUE_W-1:0]    m_tdata;
  logic                           m_tuser;

  // Shadow of the register file as the block should see it.
  logic [ict_pkg::NUM_REGS_DEFAULT-1:0] reg_known_mask = '0;
  logic [ict_pkg::VALUE_W-1:0]          reg_value [ict_pkg::NUM_REGS_DEFAULT];

  tracked_t pending_constants [$];
  int       error_count = 0;
  int       sent_count = 0;
  int       cycle_count = 0;
  int       idle_pct = 0;
  int       stall_left = 0;

  // Extremes, each instruction kind, wraparound, unknown sources,
  // destruction by other instructions and block starts.
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{'{ict_pkg::CMD_ORI,   1'b1, 5'd5,  5'd6,  16'hffff, 6'd0},  1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ADDIS, 1'b0, 5'd1,  5'd0,  16'h1234, 6'd0},  1'b1, '{1'b1, 32'h1234_0000}},
    '{'{ict_pkg::CMD_ADDI,  1'b0, 5'd1,  5'd1,  16'h5678, 6'd0},  1'b1, '{1'b1, 32'h1234_5678}},
    '{'{ict_pkg::CMD_ORI,   1'b0, 5'd1,  5'd2,  16'h00ff, 6'd0},  1'b1, '{1'b1, 32'h1234_56ff}},
    '{'{ict_pkg::CMD_ADDI,  1'b0, 5'd3,  5'd0,  16'hffff, 6'd0},  1'b1, '{1'b1, 32'hffff_ffff}},
    '{'{ict_pkg::CMD_ADDI,  1'b0, 5'd3,  5'd3,  16'h0001, 6'd0},  1'b1, '{1'b1, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ADDIS, 1'b0, 5'd31, 5'd0,  16'hffff, 6'd0},  1'b1, '{1'b1, 32'hffff_0000}},
    '{'{ict_pkg::CMD_ADDI,  1'b0, 5'd31, 5'd31, 16'h8000, 6'd0},  1'b1, '{1'b1, 32'hfffe_8000}},
    '{'{ict_pkg::CMD_ADDIS, 1'b0, 5'd6,  5'd2,  16'h0001, 6'd0},  1'b0, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_OTHER, 1'b0, 5'd31, 5'd31, 16'hffff, 6'd31}, 1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ADDI,  1'b0, 5'd4,  5'd31, 16'h0001, 6'd0},  1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ORI,   1'b0, 5'd31, 5'd7,  16'h0001, 6'd0},  1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_OTHER, 1'b0, 5'd0,  5'd0,  16'h0000, 6'd32}, 1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ORI,   1'b0, 5'd2,  5'd0,  16'h0000, 6'd0},  1'b0, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ORI,   1'b0, 5'd0,  5'd8,  16'h8000, 6'd0},  1'b0, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ADDI,  1'b0, 5'd9,  5'd0,  16'h7fff, 6'd0},  1'b1, '{1'b1, 32'h0000_7fff}},
    '{'{ict_pkg::CMD_OTHER, 1'b0, 5'd0,  5'd0,  16'h0000, 6'd0},  1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ORI,   1'b0, 5'd0,  5'd10, 16'h0001, 6'd0},  1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ADDI,  1'b1, 5'd11, 5'd1,  16'h0000, 6'd0},  1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ADDIS, 1'b1, 5'd0,  5'd0,  16'h8000, 6'd0},  1'b1, '{1'b1, 32'h8000_0000}},
    '{'{ict_pkg::CMD_ADDIS, 1'b0, 5'd12, 5'd20, 16'h0123, 6'd0},  1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_OTHER, 1'b1, 5'd31, 5'd31, 16'hffff, 6'd32}, 1'b1, '{1'b0, 32'h0000_0000}},
    '{'{ict_pkg::CMD_ADDI,  1'b0, 5'd31, 5'd0,  16'h0000, 6'd0},  1'b1, '{1'b1, 32'h0000_0000}}
  };

  immediate_constant_tracker_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one instruction to the shadow registers and returns the constant it yields.
  function automatic tracked_t track_constant(instr_t ins);
    tracked_t                    res;
    logic [ict_pkg::VALUE_W-1:0] operand;
    res = '0;
    if (ins.first)
      reg_known_mask = '0;
    case (ins.cmd) inside
      ict_pkg::CMD_ADDIS, ict_pkg::CMD_ADDI: begin
        if (ins.cmd == ict_pkg::CMD_ADDIS)
          operand = ict_pkg::VALUE_W'(ins.imm) << ict_pkg::IMM_SHIFT;
        else
          operand = {{(ict_pkg::VALUE_W - ict_pkg::IMM_W){ins.imm[ict_pkg::IMM_W-1]}},
                     ins.imm};
        // A zero source register means a literal zero, not register 0.
        if (ins.ra == '0) begin
          res.has_constant   = 1'b1;
          res.constant_value = operand;
        end else if (reg_known_mask[ins.ra]) begin
          res.has_constant   = 1'b1;
          res.constant_value = reg_value[ins.ra] + operand;
        end
        reg_known_mask[ins.rd] = res.has_constant;
        if (res.has_constant)
          reg_value[ins.rd] = res.constant_value;
      end
      ict_pkg::CMD_ORI: begin
        // The rd field is the source and the ra field the destination here.
        if (reg_known_mask[ins.rd]) begin
          res.has_constant   = 1'b1;
          res.constant_value = reg_value[ins.rd] | ict_pkg::VALUE_W'(ins.imm);
        end
        reg_known_mask[ins.ra] = res.has_constant;
        if (res.has_constant)
          reg_value[ins.ra] = res.constant_value;
      end
      default: begin
        if (ins.def < ict_pkg::NUM_REGS_DEFAULT)
          reg_known_mask[ins.def[ict_pkg::REG_W-1:0]] = 1'b0;
      end
    endcase
    return res;
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    ins.cmd   = ict_pkg::cmd_e'($urandom_range(0, 3));
    ins.first = ($urandom_range(0, 7) == 0);
    ins.rd    = ict_pkg::REG_W'($urandom_range(0, 31));
    ins.ra    = ict_pkg::REG_W'($urandom_range(0, 31));
    ins.imm   = ict_pkg::IMM_W'($urandom_range(0, 65535));
    ins.def   = ict_pkg::DEF_W'($urandom_range(0, 32));
    return ins;
  endfunction

  // Drives one transaction, waits for it to be taken and records what it should yield.
  task automatic send_instr(instr_t ins, logic typed, tracked_t typed_res);
    logic [ict_pkg::IN_TDATA_W-1:0] data;
    tracked_t                       predicted;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    data = '0;
    data[ict_pkg::IN_FIRST_LSB]                   = ins.first;
    data[ict_pkg::IN_DEST_LSB +: ict_pkg::REG_W]  = ins.rd;
    data[ict_pkg::IN_SRC_LSB +: ict_pkg::REG_W]   = ins.ra;
    data[ict_pkg::IN_IMM_LSB +: ict_pkg::IMM_W]   = ins.imm;
    data[ict_pkg::IN_DEF_LSB +: ict_pkg::DEF_W]   = ins.def;
    s_valid <= 1'b1;
    s_tdata <= data;
    s_tuser <= ins.cmd;
    do @(posedge clk_i); while (!s_ready);
    predicted = track_constant(ins);
    pending_constants.push_back(typed ? typed_res : predicted);
    sent_count++;
  endtask

  // A constant build, mostly the usual high/low pair, sometimes used as a source after.
  task automatic send_random_sequence();
    instr_t                    a;
    instr_t                    b;
    logic [ict_pkg::REG_W-1:0] r;
    int                        kind;
    kind = $urandom_range(0, 99);
    r    = ($urandom_range(0, 15) == 0) ? '0 : ict_pkg::REG_W'($urandom_range(1, 31));
    a    = random_instr();
    if (kind < 55) begin
      a.cmd   = ict_pkg::CMD_ADDIS;
      a.first = ($urandom_range(0, 19) == 0);
      a.rd    = r;
      a.ra    = ($urandom_range(0, 3) == 0) ? ict_pkg::REG_W'($urandom_range(0, 31)) : '0;
      send_instr(a, 1'b0, '0);
      b = random_instr();
      b.first = 1'b0;
      case ($urandom_range(0, 3))
        0: begin b.cmd = ict_pkg::CMD_ADDI; b.rd = r; b.ra = r; end
        1: begin b.cmd = ict_pkg::CMD_ORI;  b.rd = r; b.ra = r; end
        2: begin b.cmd = ict_pkg::CMD_ORI;  b.rd = r; end
        default: begin b.cmd = ict_pkg::CMD_ADDI; b.ra = r; end
      endcase
      send_instr(b, 1'b0, '0);
      if ($urandom_range(0, 2) == 0) begin
        a = random_instr();
        a.first = 1'b0;
        a.cmd = ($urandom_range(0, 1) == 0) ? ict_pkg::CMD_ADDI : ict_pkg::CMD_ADDIS;
        a.ra  = (b.cmd == ict_pkg::CMD_ORI) ? b.ra : b.rd;
        send_instr(a, 1'b0, '0);
      end
    end else if (kind < 80) begin
      a.cmd = ict_pkg::CMD_OTHER;
      a.def = ($urandom_range(0, 4) == 0) ? ict_pkg::DEF_W'(ict_pkg::NUM_REGS_DEFAULT)
                                          : ict_pkg::DEF_W'($urandom_range(0, 31));
      send_instr(a, 1'b0, '0);
    end else begin
      send_instr(a, 1'b0, '0);
    end
  endtask

  // Output side: random stall bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_ready    <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_result
    tracked_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_constants.size() == 0) begin
        $error("unexpected result transaction: has_constant %0d, constant_value %08h",
               m_tuser, m_tdata);
        error_count++;
      end else begin
        want = pending_constants.pop_front();
        if (m_tuser !== want.has_constant) begin
          $error("has_constant: expected %0d, actual %0d", want.has_constant, m_tuser);
          error_count++;
        end
        if (m_tdata !== want.constant_value) begin
          $error("constant_value: expected %08h, actual %08h", want.constant_value, m_tdata);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    for (int i = 0; i < DIR_ROWS; i++)
      send_instr(dir_tbl[i].ins, dir_tbl[i].typed, dir_tbl[i].res);

    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      // Alternate heavy, absent and light idling; the tail runs at full rate.
      if (sent_count >= RANDOM_ITEMS - QUIET_ITEMS)
        idle_pct = 0;
      else
        case ((sent_count / 150) % 3)
          0:       idle_pct = 25;
          1:       idle_pct = 0;
          default: idle_pct = 8;
        endcase
      send_random_sequence();
    end
    s_valid <= 1'b0;

    while (pending_constants.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_constants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
